FILE: src/tspc_pkg.sv
package tspc_pkg;

	localparam int COORD_BITS = 21;
	localparam int VTX_W      = 63;
	localparam int AXIS_W     = 2;
	localparam int SPOS_W     = 21;
	localparam int RATIO_BITS = 17;	// Q0.16 clip ratio plus the bit for exactly one

	localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
	localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
	localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

	typedef enum logic [1:0] {
		SIDE_LEFT  = 2'd0,
		SIDE_RIGHT = 2'd1,
		SIDE_BOTH  = 2'd2
	} side_t;

	typedef logic signed [COORD_BITS-1:0] crd_t;

	function automatic crd_t crd_of(logic [VTX_W-1:0] w, logic [AXIS_W-1:0] k);
		crd_t r;
		case (k)
			AXIS_X: r = w[0 +: COORD_BITS];
			AXIS_Y: r = w[COORD_BITS +: COORD_BITS];
			default: r = w[2*COORD_BITS +: COORD_BITS];
		endcase
		return r;
	endfunction

endpackage

FILE: src/tspc_ifs.sv
interface tspc_item_if;
	import tspc_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [VTX_W-1:0]          vertex_a;
	logic [VTX_W-1:0]          vertex_b;
	logic [VTX_W-1:0]          vertex_c;
	logic [VTX_W-1:0]          box_min;
	logic [VTX_W-1:0]          box_max;
	logic [AXIS_W-1:0]         split_axis;
	logic signed [SPOS_W-1:0]  split_pos;

	modport source(output valid, vertex_a, vertex_b, vertex_c, box_min, box_max,
		split_axis, split_pos, input ready);
	modport sink(input valid, vertex_a, vertex_b, vertex_c, box_min, box_max,
		split_axis, split_pos, output ready);
endinterface

interface tspc_side_if;
	import tspc_pkg::*;
	logic  valid;
	logic  ready;
	side_t side;

	modport source(output valid, side, input ready);
	modport sink(input valid, side, output ready);
endinterface

interface tspc_cfg_if;
	logic valid;
	logic ready;
	logic plane_goes_left;

	modport source(output valid, plane_goes_left, input ready);
	modport sink(input valid, plane_goes_left, output ready);
endinterface

FILE: src/triangle_split_plane_classifier_unit.sv
// Throughput: one triangle per cycle while the pipeline is not held; two restoring
// dividers, one quotient bit per stage over 17 stages, set the depth.
// The whole pipeline holds only while the output register is full, unread and
// the last stage carries a word. Reset clears valid bits and plane_goes_left.
// No clearing pass; words are accepted from the first cycle after reset.
module triangle_split_plane_classifier_unit (
	input  logic          clk,
	input  logic          arst_n,
	tspc_item_if.sink     item,
	tspc_side_if.source   result,
	tspc_cfg_if.sink      cfg
);
	import tspc_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int QW = RATIO_BITS;

	typedef logic [CB-1:0]             udv_t;
	typedef logic signed [CB:0]        dif_t;
	typedef logic signed [CB+1:0]      wid_t;
	typedef logic signed [CB+QW+1:0]   cprd_t;
	typedef logic signed [2*CB+3:0]    prd_t;
	typedef logic signed [2*CB+4:0]    acc_t;

	typedef struct packed {
		logic  early;
		side_t eside;
		logic  alone;
		crd_t  iap;
		crd_t  iaq;
		crd_t  b0p;
		crd_t  b0q;
		crd_t  b1p;
		crd_t  b1q;
		crd_t  bnp;
		crd_t  bnq;
		crd_t  bxp;
		crd_t  bxq;
	} cp_t;

	typedef struct packed {
		cp_t              c;
		udv_t             den0;
		udv_t             den1;
		udv_t             rem0;
		udv_t             rem1;
		logic [QW-1:0]    quo0;
		logic [QW-1:0]    quo1;
	} dv_t;

	function automatic dif_t sub1(crd_t x, crd_t y);
		return {x[CB-1], x} - {y[CB-1], y};
	endfunction

	logic en;
	logic pgl_q;
	logic out_vld_q;
	side_t out_side_q;
	logic vld_s25;

	assign en = !(vld_s25 && out_vld_q && !result.ready);
	assign item.ready = en;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pgl_q <= 1'b0;
		end else if (cfg.valid) begin
			pgl_q <= cfg.plane_goes_left;
		end
	end

	// ---------------- stage 1: unpack, rotate axes so the split axis comes first
	logic [AXIS_W-1:0] ax, o0, o1;
	logic [VTX_W-1:0] vw [3];
	crd_t a_s1 [3], p_s1 [3], q_s1 [3];
	crd_t bnp_s1, bnq_s1, bxp_s1, bxq_s1, pos_s1;
	logic vld_s1;

	assign vw[0] = item.vertex_a;
	assign vw[1] = item.vertex_b;
	assign vw[2] = item.vertex_c;

	always_comb begin
		case (item.split_axis)
			AXIS_X: begin
				ax = AXIS_X; o0 = AXIS_Y; o1 = AXIS_Z;
			end
			AXIS_Y: begin
				ax = AXIS_Y; o0 = AXIS_Z; o1 = AXIS_X;
			end
			default: begin
				ax = AXIS_Z; o0 = AXIS_X; o1 = AXIS_Y;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				a_s1[i] <= crd_of(vw[i], ax);
				p_s1[i] <= crd_of(vw[i], o0);
				q_s1[i] <= crd_of(vw[i], o1);
			end
			bnp_s1 <= crd_of(item.box_min, o0);
			bnq_s1 <= crd_of(item.box_min, o1);
			bxp_s1 <= crd_of(item.box_max, o0);
			bxq_s1 <= crd_of(item.box_max, o1);
			pos_s1 <= item.split_pos[CB-1:0];
		end
	end

	// ---------------- stage 2: bounding-box decision, pick lone vertex
	crd_t tmin, tmax;
	logic flat;
	logic [2:0] lt;
	logic [1:0] nl, ia, ib0, ib1;
	logic alone, early;
	side_t es;
	dif_t td, t0, t1;
	cp_t cp_s2;
	udv_t d_s2, den0_s2, den1_s2;
	logic vld_s2;

	always_comb begin
		tmin = a_s1[0];
		tmax = a_s1[0];
		for (int i = 1; i < 3; i++) begin
			if (a_s1[i] < tmin) tmin = a_s1[i];
			if (a_s1[i] > tmax) tmax = a_s1[i];
		end
		for (int i = 0; i < 3; i++) lt[i] = a_s1[i] < pos_s1;
		nl = 2'(lt[0]) + 2'(lt[1]) + 2'(lt[2]);
		flat = (tmin == tmax) && (tmin == pos_s1);
		early = 1'b1;
		es = SIDE_LEFT;
		if (flat) begin
			es = pgl_q ? SIDE_LEFT : SIDE_RIGHT;
		end else if (tmax < pos_s1) begin
			es = SIDE_LEFT;
		end else if (tmin > pos_s1) begin
			es = SIDE_RIGHT;
		end else if (nl == 2'd0) begin
			es = SIDE_RIGHT;
		end else begin
			early = 1'b0;
		end
		alone = (nl == 2'd1);
		if (alone) ia = lt[0] ? 2'd0 : (lt[1] ? 2'd1 : 2'd2);
		else ia = !lt[0] ? 2'd0 : (!lt[1] ? 2'd1 : 2'd2);
		ib0 = (ia == 2'd0) ? 2'd1 : 2'd0;
		ib1 = (ia == 2'd2) ? 2'd1 : 2'd2;
		td = alone ? sub1(pos_s1, a_s1[ia]) : sub1(a_s1[ia], pos_s1);
		t0 = alone ? sub1(a_s1[ib0], a_s1[ia]) : sub1(a_s1[ia], a_s1[ib0]);
		t1 = alone ? sub1(a_s1[ib1], a_s1[ia]) : sub1(a_s1[ia], a_s1[ib1]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cp_s2.early <= early;
			cp_s2.eside <= es;
			cp_s2.alone <= alone;
			cp_s2.iap <= p_s1[ia];
			cp_s2.iaq <= q_s1[ia];
			cp_s2.b0p <= p_s1[ib0];
			cp_s2.b0q <= q_s1[ib0];
			cp_s2.b1p <= p_s1[ib1];
			cp_s2.b1q <= q_s1[ib1];
			cp_s2.bnp <= bnp_s1;
			cp_s2.bnq <= bnq_s1;
			cp_s2.bxp <= bxp_s1;
			cp_s2.bxq <= bxq_s1;
			d_s2 <= td[CB-1:0];
			den0_s2 <= t0[CB-1:0];
			den1_s2 <= t1[CB-1:0];
		end
	end

	// ---------------- stages 3..19: two restoring dividers, one quotient bit each
	dv_t dv_s [QW];
	logic dvv_s [QW];

	for (genvar j = 0; j < QW; j++) begin : g_div
		dv_t din, dout;
		logic [CB:0] tr0, tr1, df0, df1;
		logic ge0, ge1, vin;

		if (j == 0) begin : g_first
			always_comb begin
				din.c = cp_s2;
				din.den0 = den0_s2;
				din.den1 = den1_s2;
				din.rem0 = d_s2;
				din.rem1 = d_s2;
				din.quo0 = '0;
				din.quo1 = '0;
			end
			assign tr0 = {1'b0, d_s2};
			assign tr1 = {1'b0, d_s2};
			assign vin = vld_s2;
		end else begin : g_next
			assign din = dv_s[j-1];
			assign tr0 = {din.rem0, 1'b0};
			assign tr1 = {din.rem1, 1'b0};
			assign vin = dvv_s[j-1];
		end

		always_comb begin
			ge0 = tr0 >= {1'b0, din.den0};
			ge1 = tr1 >= {1'b0, din.den1};
			df0 = ge0 ? tr0 - {1'b0, din.den0} : tr0;
			df1 = ge1 ? tr1 - {1'b0, din.den1} : tr1;
			dout = din;
			dout.rem0 = df0[CB-1:0];
			dout.rem1 = df1[CB-1:0];
			dout.quo0 = {din.quo0[QW-2:0], ge0};
			dout.quo1 = {din.quo1[QW-2:0], ge1};
		end

		always_ff @(posedge clk) begin
			if (en) dv_s[j] <= dout;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dvv_s[j] <= 1'b0;
			end else if (en) begin
				dvv_s[j] <= vin;
			end
		end
	end

	// ---------------- stage 20: ratio times edge
	dv_t dl;
	dif_t e0p, e0q, e1p, e1q;
	cp_t c_s20;
	cprd_t pr0p_s20, pr0q_s20, pr1p_s20, pr1q_s20;
	logic up0p_s20, up0q_s20, vld_s20;

	assign dl = dv_s[QW-1];
	assign e0p = sub1(dl.c.b0p, dl.c.iap);
	assign e0q = sub1(dl.c.b0q, dl.c.iaq);
	assign e1p = sub1(dl.c.b1p, dl.c.iap);
	assign e1q = sub1(dl.c.b1q, dl.c.iaq);

	always_ff @(posedge clk) begin
		if (en) begin
			c_s20 <= dl.c;
			pr0p_s20 <= $signed({1'b0, dl.quo0}) * e0p;
			pr0q_s20 <= $signed({1'b0, dl.quo0}) * e0q;
			pr1p_s20 <= $signed({1'b0, dl.quo1}) * e1p;
			pr1q_s20 <= $signed({1'b0, dl.quo1}) * e1q;
			up0p_s20 <= e0p > 0;
			up0q_s20 <= e0q > 0;
		end
	end

	// ---------------- stage 21: cut segment end points
	cprd_t sh0p, sh0q, sh1p, sh1q;
	cp_t c_s21;
	wid_t s1p_s21, s1q_s21, s2p_s21, s2q_s21;
	logic up0p_s21, up0q_s21, vld_s21;

	// arithmetic shift floors toward minus infinity
	assign sh0p = pr0p_s20 >>> 16;
	assign sh0q = pr0q_s20 >>> 16;
	assign sh1p = pr1p_s20 >>> 16;
	assign sh1q = pr1q_s20 >>> 16;

	always_ff @(posedge clk) begin
		if (en) begin
			c_s21 <= c_s20;
			s1p_s21 <= wid_t'(c_s20.iap) + sh0p[CB+1:0];
			s1q_s21 <= wid_t'(c_s20.iaq) + sh0q[CB+1:0];
			s2p_s21 <= wid_t'(c_s20.iap) + sh1p[CB+1:0];
			s2q_s21 <= wid_t'(c_s20.iaq) + sh1q[CB+1:0];
			up0p_s21 <= up0p_s20;
			up0q_s21 <= up0q_s20;
		end
	end

	// ---------------- stage 22: extent test, normal, box corners
	wid_t smnp, smxp, smnq, smxq, n0, n1;
	logic xh, xabove;
	logic xup;
	cp_t c_s22;
	wid_t s1p_s22, s1q_s22, n0_s22, n1_s22;
	crd_t k0p_s22, k0q_s22, k1p_s22, k1q_s22;
	logic xh_s22, vld_s22;
	side_t xs_s22;

	always_comb begin
		smnp = (s1p_s21 < s2p_s21) ? s1p_s21 : s2p_s21;
		smxp = (s1p_s21 < s2p_s21) ? s2p_s21 : s1p_s21;
		smnq = (s1q_s21 < s2q_s21) ? s1q_s21 : s2q_s21;
		smxq = (s1q_s21 < s2q_s21) ? s2q_s21 : s1q_s21;
		xh = 1'b1;
		xabove = 1'b0;
		xup = up0p_s21;
		if (smxp < wid_t'(c_s21.bnp)) begin
			xabove = 1'b0;
		end else if (smnp > wid_t'(c_s21.bxp)) begin
			xabove = 1'b1;
		end else if (smxq < wid_t'(c_s21.bnq)) begin
			xabove = 1'b0; xup = up0q_s21;
		end else if (smnq > wid_t'(c_s21.bxq)) begin
			xabove = 1'b1; xup = up0q_s21;
		end else begin
			xh = 1'b0;
		end
		n0 = s2q_s21 - s1q_s21;
		n1 = s1p_s21 - s2p_s21;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s22 <= c_s21;
			s1p_s22 <= s1p_s21;
			s1q_s22 <= s1q_s21;
			n0_s22 <= n0;
			n1_s22 <= n1;
			k0p_s22 <= (n0 > 0) ? c_s21.bxp : c_s21.bnp;
			k1p_s22 <= (n0 > 0) ? c_s21.bnp : c_s21.bxp;
			k0q_s22 <= (n1 > 0) ? c_s21.bxq : c_s21.bnq;
			k1q_s22 <= (n1 > 0) ? c_s21.bnq : c_s21.bxq;
			xh_s22 <= xh;
			xs_s22 <= ((xup ^ xabove) ^ c_s21.alone) ? SIDE_LEFT : SIDE_RIGHT;
		end
	end

	// ---------------- stage 23: offsets from box corners
	logic early_s23, alone_s23, xh_s23, vld_s23;
	side_t es_s23, xs_s23;
	wid_t n0_s23, n1_s23, x1_s23, y1_s23, x2_s23, y2_s23, xq_s23, yq_s23;

	always_ff @(posedge clk) begin
		if (en) begin
			early_s23 <= c_s22.early;
			es_s23 <= c_s22.eside;
			alone_s23 <= c_s22.alone;
			xh_s23 <= xh_s22;
			xs_s23 <= xs_s22;
			n0_s23 <= n0_s22;
			n1_s23 <= n1_s22;
			x1_s23 <= s1p_s22 - wid_t'(k0p_s22);
			y1_s23 <= s1q_s22 - wid_t'(k0q_s22);
			x2_s23 <= s1p_s22 - wid_t'(k1p_s22);
			y2_s23 <= s1q_s22 - wid_t'(k1q_s22);
			xq_s23 <= wid_t'(c_s22.iap) - wid_t'(k0p_s22);
			yq_s23 <= wid_t'(c_s22.iaq) - wid_t'(k0q_s22);
		end
	end

	// ---------------- stage 24: dot product terms
	logic early_s24, alone_s24, xh_s24, vld_s24;
	side_t es_s24, xs_s24;
	prd_t m1a_s24, m1b_s24, m2a_s24, m2b_s24, qa_s24, qb_s24;

	always_ff @(posedge clk) begin
		if (en) begin
			early_s24 <= early_s23;
			es_s24 <= es_s23;
			alone_s24 <= alone_s23;
			xh_s24 <= xh_s23;
			xs_s24 <= xs_s23;
			m1a_s24 <= x1_s23 * n0_s23;
			m1b_s24 <= y1_s23 * n1_s23;
			m2a_s24 <= x2_s23 * n0_s23;
			m2b_s24 <= y2_s23 * n1_s23;
			qa_s24 <= xq_s23 * n0_s23;
			qb_s24 <= yq_s23 * n1_s23;
		end
	end

	// ---------------- stage 25: sums and final decision
	acc_t m1, m2, q1;
	side_t fs;
	side_t side_s25;

	always_comb begin
		m1 = acc_t'(m1a_s24) + acc_t'(m1b_s24);
		m2 = acc_t'(m2a_s24) + acc_t'(m2b_s24);
		q1 = acc_t'(qa_s24) + acc_t'(qb_s24);
		if (early_s24) begin
			fs = es_s24;
		end else if (xh_s24) begin
			fs = xs_s24;
		end else if (m1[2*CB+4] != m2[2*CB+4]) begin
			fs = SIDE_BOTH;
		end else begin
			fs = (alone_s24 ^ (m1[2*CB+4] == q1[2*CB+4])) ? SIDE_LEFT : SIDE_RIGHT;
		end
	end

	always_ff @(posedge clk) begin
		if (en) side_s25 <= fs;
	end

	// ---------------- valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s20 <= 1'b0;
			vld_s21 <= 1'b0;
			vld_s22 <= 1'b0;
			vld_s23 <= 1'b0;
			vld_s24 <= 1'b0;
			vld_s25 <= 1'b0;
		end else if (en) begin
			vld_s1 <= item.valid;
			vld_s2 <= vld_s1;
			vld_s20 <= dvv_s[QW-1];
			vld_s21 <= vld_s20;
			vld_s22 <= vld_s21;
			vld_s23 <= vld_s22;
			vld_s24 <= vld_s23;
			vld_s25 <= vld_s24;
		end
	end

	// ---------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (!out_vld_q || result.ready) begin
			out_vld_q <= vld_s25;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || result.ready) out_side_q <= side_s25;
	end

	assign result.valid = out_vld_q;
	assign result.side = out_side_q;

endmodule

FILE: src/tspc_checker.sv
module tspc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       item_ready,
	input logic       result_valid,
	input logic       result_ready,
	input logic [1:0] result_side,
	input logic       cfg_ready
);
	import tspc_pkg::*;

	// input stalls only when the output is backed up
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> (result_valid && !result_ready))
		else $error("input stalled without output backpressure");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |=> (result_valid && $stable(result_side)))
		else $error("unread result word dropped or changed");

	a_side_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result_side == SIDE_LEFT || result_side == SIDE_RIGHT ||
			result_side == SIDE_BOTH))
		else $error("result side code out of range");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("config port not ready");

endmodule

bind triangle_split_plane_classifier_unit tspc_checker u_tspc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.item_ready(item.ready),
	.result_valid(result.valid),
	.result_ready(result.ready),
	.result_side(result.side),
	.cfg_ready(cfg.ready)
);
